/* src/min_gap_and_range_of_set_unit_defines.svh */
// Assertion macros used by the checker file.
`ifndef MIN_GAP_AND_RANGE_OF_SET_UNIT_DEFINES_SVH
`define MIN_GAP_AND_RANGE_OF_SET_UNIT_DEFINES_SVH
// Same-cycle implication, sampled on aclk, quiet during reset.
`define MGR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, sampled on aclk, quiet during reset.
`define MGR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* src/mgr_pkg.sv */
// ----------------------------------------------------------------------------
// mgr_pkg
// Shared constants for the min gap and range unit.
// ----------------------------------------------------------------------------
`default_nettype none
package mgr_pkg;
    typedef logic [1:0] status_t;
    localparam status_t ST_ACCEPTED = 2'd0;
    localparam status_t ST_FULL     = 2'd1;
    localparam status_t ST_SPANS    = 2'd2;
    localparam status_t ST_TOO_FEW  = 2'd3;
    localparam int      CAP_W       = 11;
    localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;
endpackage
`default_nettype wire

/* src/mgr_store.sv */
// ----------------------------------------------------------------------------
// mgr_store
// Single-port-write, single-port-read value memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module mgr_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [31:0]   wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [31:0]   rd_data
);
    logic [31:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

/* src/min_gap_and_range_of_set_unit.sv */
// ----------------------------------------------------------------------------
// min_gap_and_range_of_set_unit
// Collects signed values into a memory and, at the end of a set, reports the
// smallest gap between sorted neighbors and the overall range.
// ----------------------------------------------------------------------------
// Channel   Direction  Beat content
// s_        in         value, end_of_set
// m_        out        status, value_dropped, shortest_span, longest_span
// cfg_      in         capacity (write only)
//
// A value beat that does not close a set gets its result beat the next cycle.
// A closing beat that leaves fewer than two stored values gets a too-few result
// beat; with n >= 2 stored values it runs an in-place bubble sort over the value
// memory: each pass issues one memory read per entry, waits for the last read to
// land and ends in a wrap state, and passes repeat until one makes no exchange;
// a done state then posts the result beat. The pass without exchange also yields
// the smallest gap. Reset (synchronous, active low) clears the set; memory
// contents are not cleared. Input is held off while a sort runs or while an
// unaccepted result beat waits.
// ----------------------------------------------------------------------------
`default_nettype none
module min_gap_and_range_of_set_unit
    import mgr_pkg::*;
#(
    parameter int STORE_DEPTH = 1024
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic signed [31:0] s_value,
    input  wire logic              s_end_of_set,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_status,
    output logic                   m_value_dropped,
    output logic [31:0]            m_shortest_span,
    output logic [31:0]            m_longest_span,
    input  wire logic              cfg_wr_en,
    input  wire logic [CAP_W-1:0]  cfg_wr_data
);
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    // Sequencer codes.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SORT = 2'd1;
    localparam logic [1:0] S_WRAP = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CAP_W-1:0] cap_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic [31:0]      min_reg, min_next, max_reg, max_next;
    logic [CW-1:0]    n_reg, n_next;
    logic [CW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    pend_idx_reg, pend_idx_next;
    logic [31:0]      carry_reg, carry_next;
    logic             swap_reg, swap_next;
    logic [31:0]      gap_reg, gap_next;
    logic             drop_reg, drop_next;
    logic             m_valid_reg, m_valid_next;
    logic [1:0]       m_status_reg, m_status_next;
    logic             m_drop_reg, m_drop_next;
    logic [31:0]      m_short_reg, m_short_next;
    logic [31:0]      m_long_reg, m_long_next;

    logic             wr_en, rd_en;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [31:0]      wr_data, rd_data;

    logic             accept, fits, below;
    logic [31:0]      flipped, diff;
    logic [CW-1:0]    cnt_after;
    logic [AW-1:0]    last_idx;

    mgr_store #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready         = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept          = s_valid && s_ready;
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_value_dropped = m_drop_reg;
    assign m_shortest_span = m_short_reg;
    assign m_longest_span  = m_long_reg;

    // Flipping the sign bit makes unsigned order match signed order.
    assign flipped   = s_value ^ SIGN_FLIP;
    assign fits      = (LW'(count_reg) < LW'(cap_reg)) && (LW'(count_reg) < LW'(STORE_DEPTH));
    assign cnt_after = fits ? count_reg + CW'(1) : count_reg;
    assign last_idx  = AW'(n_reg - CW'(1));
    assign below     = rd_data < carry_reg;
    assign diff      = rd_data - carry_reg;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        n_next        = n_reg;
        rd_ptr_next   = rd_ptr_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        carry_next    = carry_reg;
        swap_next     = swap_reg;
        gap_next      = gap_reg;
        drop_next     = drop_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_drop_next   = m_drop_reg;
        m_short_next  = m_short_reg;
        m_long_next   = m_long_reg;
        wr_en         = 1'b0;
        wr_addr       = count_reg[AW-1:0];
        wr_data       = flipped;
        rd_en         = 1'b0;
        rd_addr       = rd_ptr_reg[AW-1:0];

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (fits) begin
                        wr_en      = 1'b1;
                        count_next = cnt_after;
                        if (count_reg == '0) begin
                            min_next = flipped;
                            max_next = flipped;
                        end else begin
                            if (flipped < min_reg) min_next = flipped;
                            if (flipped > max_reg) max_next = flipped;
                        end
                    end
                    m_drop_next  = !fits;
                    m_short_next = '0;
                    m_long_next  = '0;
                    if (!s_end_of_set) begin
                        m_valid_next  = 1'b1;
                        m_status_next = fits ? ST_ACCEPTED : ST_FULL;
                    end else if (cnt_after < CW'(2)) begin
                        m_valid_next  = 1'b1;
                        m_status_next = ST_TOO_FEW;
                        count_next    = '0;
                    end else begin
                        n_next      = cnt_after;
                        drop_next   = !fits;
                        rd_ptr_next = '0;
                        swap_next   = 1'b0;
                        gap_next    = '1;
                        state_next  = S_SORT;
                    end
                end
            end
            S_SORT: begin
                if (rd_ptr_reg < n_reg) begin
                    rd_en         = 1'b1;
                    rd_ptr_next   = rd_ptr_reg + CW'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = rd_ptr_reg[AW-1:0];
                end
                if (pend_reg) begin
                    if (pend_idx_reg == '0) begin
                        carry_next = rd_data;
                    end else begin
                        // Larger value moves on, smaller one settles below.
                        wr_en      = 1'b1;
                        wr_addr    = pend_idx_reg - AW'(1);
                        wr_data    = below ? rd_data : carry_reg;
                        carry_next = below ? carry_reg : rd_data;
                        if (below) begin
                            swap_next = 1'b1;
                        end else if (diff < gap_reg) begin
                            gap_next = diff;
                        end
                    end
                    if (pend_idx_reg == last_idx) begin
                        state_next = S_WRAP;
                    end
                end
            end
            S_WRAP: begin
                wr_en   = 1'b1;
                wr_addr = last_idx;
                wr_data = carry_reg;
                if (swap_reg) begin
                    rd_ptr_next = '0;
                    swap_next   = 1'b0;
                    gap_next    = '1;
                    state_next  = S_SORT;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                m_valid_next  = 1'b1;
                m_status_next = ST_SPANS;
                m_drop_next   = drop_reg;
                m_short_next  = gap_reg;
                m_long_next   = max_reg - min_reg;
                count_next    = '0;
                state_next    = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cap_reg     <= CAP_W'(1024);
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        min_reg      <= min_next;
        max_reg      <= max_next;
        n_reg        <= n_next;
        rd_ptr_reg   <= rd_ptr_next;
        pend_idx_reg <= pend_idx_next;
        carry_reg    <= carry_next;
        swap_reg     <= swap_next;
        gap_reg      <= gap_next;
        drop_reg     <= drop_next;
        m_status_reg <= m_status_next;
        m_drop_reg   <= m_drop_next;
        m_short_reg  <= m_short_next;
        m_long_reg   <= m_long_next;
    end
endmodule
`default_nettype wire

/* src/mgr_checker.sv */
// ----------------------------------------------------------------------------
// mgr_checker
// Port-level checks on the result channel of the min gap and range unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "min_gap_and_range_of_set_unit_defines.svh"
module mgr_checker
    import mgr_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_status,
    input wire logic        m_value_dropped,
    input wire logic [31:0] m_shortest_span,
    input wire logic [31:0] m_longest_span
);
    // An accepted value is never reported as dropped; a full store always is.
    `MGR_ASSERT_IMP(a_accept_not_dropped, m_valid && m_status == ST_ACCEPTED, !m_value_dropped)
    `MGR_ASSERT_IMP(a_full_dropped, m_valid && m_status == ST_FULL, m_value_dropped)
    // Spans are zero unless the set produced them.
    `MGR_ASSERT_IMP(a_spans_zero, m_valid && m_status != ST_SPANS,
                    m_shortest_span == '0 && m_longest_span == '0)
    // The smallest gap can never exceed the whole range.
    `MGR_ASSERT_IMP(a_gap_in_range, m_valid && m_status == ST_SPANS,
                    m_shortest_span <= m_longest_span)
    `MGR_ASSERT_NXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_status))
endmodule

bind min_gap_and_range_of_set_unit mgr_checker u_mgr_checker (.*);
`default_nettype wire

/* tb/min_gap_and_range_of_set_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_gap_and_range_of_set_unit_tb
// Drives sets of signed values through the unit and checks every result beat
// against a behavioral predictor of the store, its limit and the span logic.
// ----------------------------------------------------------------------------
module min_gap_and_range_of_set_unit_tb;
    import mgr_pkg::*;

    localparam int DEPTH      = 1024;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        status_t     status;
        logic        dropped;
        logic [31:0] shortest;
        logic [31:0] longest;
    } span_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_value = '0;
    logic s_end_of_set = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_status;
    logic m_value_dropped;
    logic [31:0] m_shortest_span;
    logic [31:0] m_longest_span;
    logic cfg_wr_en = 1'b0;
    logic [CAP_W-1:0] cfg_wr_data = '0;

    // Idle percentages for the sender and the receiver.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int quiet_cycles = 0;

    span_result_t expected_q[$];

    // Predictor state. Values are held with the sign bit flipped so that an
    // unsigned comparison orders them as signed numbers.
    logic [31:0] set_values[$];
    logic [31:0] set_min;
    logic [31:0] set_max;
    int unsigned cap_limit = 1024;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    min_gap_and_range_of_set_unit #(.STORE_DEPTH(DEPTH)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_value(s_value), .s_end_of_set(s_end_of_set),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_value_dropped(m_value_dropped),
        .m_shortest_span(m_shortest_span), .m_longest_span(m_longest_span),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    // Works out the result beat for one accepted input beat and updates the
    // predicted set contents.
    function automatic span_result_t predict_spans(logic [31:0] value, logic last);
        span_result_t r;
        logic [31:0] key;
        logic [31:0] sorted[$];
        int unsigned lim;
        r = '0;
        key = value ^ SIGN_FLIP;
        lim = (cap_limit > DEPTH) ? DEPTH : cap_limit;
        if (set_values.size() < lim) begin
            if (set_values.size() == 0) begin
                set_min = key;
                set_max = key;
            end else begin
                if (key < set_min) set_min = key;
                if (key > set_max) set_max = key;
            end
            set_values.insert(set_values.size(), key);
            r.status = ST_ACCEPTED;
        end else begin
            r.dropped = 1'b1;
            r.status = ST_FULL;
        end
        if (last) begin
            if (set_values.size() < 2) begin
                r.status = ST_TOO_FEW;
            end else begin
                sorted = set_values;
                sorted.sort();
                r.shortest = 32'hFFFF_FFFF;
                for (int i = 1; i < sorted.size(); i++) begin
                    if (sorted[i] - sorted[i-1] < r.shortest)
                        r.shortest = sorted[i] - sorted[i-1];
                end
                r.longest = set_max - set_min;
                r.status = ST_SPANS;
            end
            set_values.delete();
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Sends one beat: optional idle cycles first, then valid held until the
    // handshake completes. Valid stays up after the handshake so that a beat
    // sent right away follows with no gap; drain_results lowers it.
    task automatic send_beat(logic [31:0] value, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        s_end_of_set <= last;
        do @(posedge aclk); while (!s_ready);
        expected_q.insert(expected_q.size(), predict_spans(value, last));
    endtask

    // Stops sending and waits until every predicted beat has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cap_limit = cap;
    endtask

    // Receiver: random back-pressure and one comparison per result beat.
    always @(posedge aclk) begin
        span_result_t want;
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result beat", {30'd0, m_status}, '0);
            end else begin
                want = expected_q.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", m_status, want.status);
                if (m_value_dropped !== want.dropped)
                    report_mismatch("value_dropped", m_value_dropped, want.dropped);
                if (m_shortest_span !== want.shortest)
                    report_mismatch("shortest_span", m_shortest_span, want.shortest);
                if (m_longest_span !== want.longest)
                    report_mismatch("longest_span", m_longest_span, want.longest);
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Extremes, both signs, equal values and the short-set cases.
    task automatic test_directed();
        send_beat(32'h7FFF_FFFF, 1'b0);
        send_beat(32'h8000_0000, 1'b1);
        send_beat(32'h0000_0005, 1'b1);
        send_beat(32'hFFFF_FFFF, 1'b0);
        send_beat(32'hFFFF_FFFF, 1'b0);
        send_beat(32'h0000_0000, 1'b1);
        send_beat(32'h1234_5678, 1'b0);
        send_beat(32'hEDCB_A987, 1'b0);
        send_beat(32'h0000_0001, 1'b0);
        send_beat(32'h5555_5555, 1'b0);
        send_beat(32'hAAAA_AAAA, 1'b1);
    endtask

    // Small capacities: full store, drop on the closing beat, zero capacity,
    // and a limit change while a set is open.
    task automatic test_capacity_limits();
        write_capacity(11'd3);
        for (int i = 0; i < 5; i++) send_beat($urandom, 1'b0);
        send_beat($urandom, 1'b1);
        write_capacity(11'd0);
        send_beat(32'h0000_0010, 1'b0);
        send_beat(32'h0000_0020, 1'b1);
        write_capacity(11'd1);
        send_beat(32'h8000_0000, 1'b0);
        send_beat(32'h7FFF_FFFF, 1'b1);
        write_capacity(11'd8);
        for (int i = 0; i < 6; i++) send_beat($urandom, 1'b0);
        write_capacity(11'd2);
        send_beat($urandom, 1'b1);
        write_capacity(11'h7FF);
    endtask

    // Random sets, mostly short so the sort stays cheap, values drawn either
    // from a narrow window (to provoke small and zero gaps) or the full range.
    task automatic test_random_sets(int beats);
        int sent;
        int len;
        logic [31:0] base;
        logic [31:0] v;
        sent = 0;
        while (sent < beats) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
            base = $urandom;
            for (int i = 0; i < len; i++) begin
                v = $urandom_range(1) ? base + $urandom_range(15) : $urandom;
                send_beat(v, i == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_capacity_limits();

        send_idle_pct = 0;  recv_stall_pct = 0;  test_random_sets(100);
        send_idle_pct = 67; recv_stall_pct = 0;  test_random_sets(100);
        drain_results();
        write_capacity(11'd12);
        send_idle_pct = 0;  recv_stall_pct = 67; test_random_sets(100);
        write_capacity(11'd1024);
        send_idle_pct = 7;  recv_stall_pct = 7;  test_random_sets(100);

        drain_results();
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
